// ===== hdl/edid_pkg.sv =====
// ----------------------------------------------------------------------------
// EDID decoder package
// Shared types, byte offsets and helper functions for the base block decoder.
// ----------------------------------------------------------------------------
package edid_pkg;

  // Record kinds carried on the result channel
  typedef enum logic [1:0] {
    KIND_INFO   = 2'd0,
    KIND_MODE   = 2'd1,
    KIND_NAME   = 2'd2,
    KIND_TIMING = 2'd3
  } kind_t;

  // Aspect codes in the top bits of a standard mode's second byte
  typedef enum logic [1:0] {
    ASPECT_16_10 = 2'd0,
    ASPECT_4_3   = 2'd1,
    ASPECT_5_4   = 2'd2,
    ASPECT_16_9  = 2'd3
  } aspect_t;

  localparam int IdxW  = 7;   // byte index within the 128-byte block
  localparam int RelW  = 5;   // byte offset within an 18-byte descriptor
  localparam int DimW  = 13;  // timing and size fields

  localparam logic [IdxW-1:0] IDX_VERSION    = 7'd18;
  localparam logic [IdxW-1:0] IDX_REVISION   = 7'd19;
  localparam logic [IdxW-1:0] IDX_WIDTH_CM   = 7'd21;
  localparam logic [IdxW-1:0] IDX_HEIGHT_CM  = 7'd22;
  localparam logic [IdxW-1:0] IDX_MODE_FIRST = 7'd38;
  localparam logic [IdxW-1:0] IDX_DESC_FIRST = 7'd54;
  localparam logic [IdxW-1:0] IDX_DESC_END   = 7'd126;

  localparam logic [RelW-1:0] DESC_LEN     = 5'd18;
  localparam logic [RelW-1:0] REL_TAG      = 5'd3;
  localparam logic [RelW-1:0] REL_TEXT     = 5'd5;
  localparam logic [RelW-1:0] REL_FLAGS    = 5'd17;
  localparam int              DescHoldDepth = 17;

  localparam logic [7:0] TAG_NAME = 8'hFC;
  localparam logic [7:0] CHAR_LF  = 8'h0A;

  localparam logic [7:0] MODE_BIAS    = 8'd31;
  localparam logic [5:0] REFRESH_BIAS = 6'd60;

  // Result payload as held in the output register
  typedef struct packed {
    kind_t            record_kind;
    logic [15:0]      pixel_clock;
    logic [DimW-1:0]  h_pixels;
    logic [DimW-1:0]  h_sync_start;
    logic [DimW-1:0]  h_sync_end;
    logic [DimW-1:0]  h_total;
    logic [DimW-1:0]  v_lines;
    logic [DimW-1:0]  v_sync_start;
    logic [DimW-1:0]  v_sync_end;
    logic [DimW-1:0]  v_total;
    logic [1:0]       sync_polarity;
    logic [7:0]       name_char;
  } rec_t;

  // Offset within a descriptor for an index in the descriptor area
  function automatic logic [RelW-1:0] desc_rel(input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] r;
    r = idx - IDX_DESC_FIRST;
    if (r >= 7'd54) begin
      r = r - 7'd54;
    end else if (r >= 7'd36) begin
      r = r - 7'd36;
    end else if (r >= 7'd18) begin
      r = r - 7'd18;
    end
    return r[RelW-1:0];
  endfunction

  // Height of a standard mode from its width and aspect code, truncated
  function automatic logic [DimW-1:0] mode_height(input logic [11:0] x,
                                                  input logic [1:0]  aspect);
    logic [15:0] x5;
    logic [15:0] x3;
    logic [15:0] x9;
    logic [13:0] x4;
    logic [30:0] prod;
    logic [DimW-1:0] y;
    x5   = {4'd0, x} * 16'd5;
    x3   = {4'd0, x} * 16'd3;
    x9   = {4'd0, x} * 16'd9;
    x4   = {x, 2'b00};
    // divide by 5: multiply by 2^18/5 rounded up, exact below 2^18
    prod = {17'd0, x4} * 31'd52429;
    case (aspect)
      ASPECT_16_10: y = x5[15:3];           // 16:10
      ASPECT_4_3:   y = x3[14:2];           // 4:3
      ASPECT_5_4:   y = prod[30:18];        // 5:4
      default:      y = {1'b0, x9[15:4]};   // 16:9
    endcase
    return y;
  endfunction

endpackage

// ===== hdl/edid_byte_if.sv =====
// ----------------------------------------------------------------------------
// EDID byte channel
// One byte of the base block per beat, with a start-of-block flag.
// ----------------------------------------------------------------------------
interface edid_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] edid_byte;
  logic       block_start;

  modport source (output valid, output edid_byte, output block_start, input ready);
  modport sink   (input valid, input edid_byte, input block_start, output ready);
endinterface

// ===== hdl/edid_rec_if.sv =====
// ----------------------------------------------------------------------------
// EDID record channel
// One decoded record per beat: info, standard mode, name character or timing.
// ----------------------------------------------------------------------------
interface edid_rec_if;
  logic                            valid;
  logic                            ready;
  edid_pkg::kind_t                 record_kind;
  logic [15:0]                     pixel_clock;
  logic [edid_pkg::DimW-1:0]       h_pixels;
  logic [edid_pkg::DimW-1:0]       h_sync_start;
  logic [edid_pkg::DimW-1:0]       h_sync_end;
  logic [edid_pkg::DimW-1:0]       h_total;
  logic [edid_pkg::DimW-1:0]       v_lines;
  logic [edid_pkg::DimW-1:0]       v_sync_start;
  logic [edid_pkg::DimW-1:0]       v_sync_end;
  logic [edid_pkg::DimW-1:0]       v_total;
  logic [1:0]                      sync_polarity;
  logic [7:0]                      name_char;

  modport source (
    output valid, input ready,
    output record_kind, output pixel_clock,
    output h_pixels, output h_sync_start, output h_sync_end, output h_total,
    output v_lines, output v_sync_start, output v_sync_end, output v_total,
    output sync_polarity, output name_char
  );
  modport sink (
    input valid, output ready,
    input record_kind, input pixel_clock,
    input h_pixels, input h_sync_start, input h_sync_end, input h_total,
    input v_lines, input v_sync_start, input v_sync_end, input v_total,
    input sync_polarity, input name_char
  );
endinterface

// ===== hdl/edid_block_decoder.sv =====
// ----------------------------------------------------------------------------
// EDID base block decoder
// Parses a 128-byte EDID 1.3 base block streamed one byte per beat and emits
// info, standard mode, monitor name and detailed timing records.
// ----------------------------------------------------------------------------
//
//   channel   direction  beat payload                           per beat
//   --------  ---------  -------------------------------------  -----------
//   bytes     in         edid_byte, block_start                 one byte
//   records   out        record_kind plus mode/timing fields    one record
//
// Cycles: one byte per cycle while records.ready does not stall the input; a record
//   appears on the output register the cycle after the byte that completes it. Only
//   the decode logic between the byte handshake and the output register sets this.
// Reset: synchronous rst clears the byte index, name flags and output valid.
// Stalls: bytes are taken whenever the output register is empty or being
//   drained, so a waiting record blocks input only while records.ready is low.
// Bytes 0..17, 20, 23..37 and 126..127 update the index only.
//
module edid_block_decoder (
  input  logic               clk,
  input  logic               rst,
  edid_byte_if.sink          bytes,
  edid_rec_if.source         records
);

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic byte_fire;
  logic out_valid;

  assign bytes.ready = !out_valid || records.ready;
  assign byte_fire   = bytes.valid && bytes.ready;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  logic [edid_pkg::IdxW-1:0] byte_index;
  logic [7:0]                descriptor_hold [edid_pkg::DescHoldDepth];
  logic [7:0]                header_hold [3];
  logic [7:0]                mode_first_byte;
  logic                      name_active;
  logic                      name_finished;
  logic                      name_active_next;
  logic                      name_finished_next;

  edid_pkg::rec_t            out_rec;
  edid_pkg::rec_t            out_rec_next;
  logic                      emit;

  // --------------------------------------------------------------------------
  // Decode of the current byte
  // --------------------------------------------------------------------------
  logic [7:0]                b;
  logic [edid_pkg::IdxW-1:0] idx;
  logic [edid_pkg::RelW-1:0] rel;
  logic                      in_mode;
  logic                      in_desc;
  logic [8:0]                mode_sum;
  logic [11:0]               mode_x;
  logic [11:0]               ha;
  logic [11:0]               hb;
  logic [9:0]                hfp;
  logic [9:0]                hsw;
  logic [11:0]               va;
  logic [11:0]               vb;
  logic [5:0]                vfp;
  logic [5:0]                vsw;
  logic [edid_pkg::DimW-1:0] h_ss;
  logic [edid_pkg::DimW-1:0] v_ss;
  logic                      desc_zero_led;

  assign b       = bytes.edid_byte;
  // a start flag forces byte 0 regardless of where the count stands
  assign idx     = bytes.block_start ? '0 : byte_index;
  assign rel     = edid_pkg::desc_rel(idx);
  assign in_mode = (idx >= edid_pkg::IDX_MODE_FIRST) && (idx < edid_pkg::IDX_DESC_FIRST);
  assign in_desc = (idx >= edid_pkg::IDX_DESC_FIRST) && (idx < edid_pkg::IDX_DESC_END);

  // standard mode width: (first byte + 31) * 8
  assign mode_sum = {1'b0, mode_first_byte} + {1'b0, edid_pkg::MODE_BIAS};
  assign mode_x   = {mode_sum, 3'b000};

  // unpack detailed timing fields from the held descriptor bytes
  assign ha  = {descriptor_hold[4][7:4], descriptor_hold[2]};
  assign hb  = {descriptor_hold[4][3:0], descriptor_hold[3]};
  assign hfp = {descriptor_hold[11][7:6], descriptor_hold[8]};
  assign hsw = {descriptor_hold[11][5:4], descriptor_hold[9]};
  assign va  = {descriptor_hold[7][7:4], descriptor_hold[5]};
  assign vb  = {descriptor_hold[7][3:0], descriptor_hold[6]};
  assign vfp = {descriptor_hold[11][3:2], descriptor_hold[10][7:4]};
  assign vsw = {descriptor_hold[11][1:0], descriptor_hold[10][3:0]};
  assign h_ss = {1'b0, ha} + {3'd0, hfp};
  assign v_ss = {1'b0, va} + {7'd0, vfp};

  assign desc_zero_led = (descriptor_hold[0] == 8'd0) && (descriptor_hold[1] == 8'd0)
                         && (descriptor_hold[2] == 8'd0);

  always_comb begin
    out_rec_next       = '0;
    emit               = 1'b0;
    name_active_next   = name_active;
    name_finished_next = name_finished;

    if (idx == edid_pkg::IDX_HEIGHT_CM) begin
      // info record: version, revision, size in cm
      emit                     = 1'b1;
      out_rec_next.record_kind = edid_pkg::KIND_INFO;
      out_rec_next.h_pixels    = {5'd0, header_hold[0]};
      out_rec_next.v_lines     = {5'd0, header_hold[1]};
      out_rec_next.h_total     = {5'd0, header_hold[2]};
      out_rec_next.v_total     = {5'd0, b};
    end else if (in_mode && idx[0]) begin
      // second byte of a standard mode: aspect code and refresh
      emit                     = 1'b1;
      out_rec_next.record_kind = edid_pkg::KIND_MODE;
      out_rec_next.pixel_clock = {10'd0, b[5:0]} + {10'd0, edid_pkg::REFRESH_BIAS};
      out_rec_next.h_pixels    = {1'b0, mode_x};
      out_rec_next.v_lines     = edid_pkg::mode_height(mode_x, b[7:6]);
    end else if (in_desc) begin
      if (rel == '0) begin
        name_active_next   = 1'b0;
        name_finished_next = 1'b0;
      end
      if ((rel == edid_pkg::REL_TAG) && desc_zero_led && (b == edid_pkg::TAG_NAME)) begin
        name_active_next   = 1'b1;
        name_finished_next = 1'b0;
      end
      if ((rel >= edid_pkg::REL_TEXT) && name_active_next && !name_finished_next) begin
        if (b == edid_pkg::CHAR_LF) begin
          name_finished_next = 1'b1;
        end else begin
          emit                     = 1'b1;
          out_rec_next.record_kind = edid_pkg::KIND_NAME;
          out_rec_next.name_char   = b;
        end
      end
      // last descriptor byte carries the sync flags; a nonzero clock means timing
      if ((rel == edid_pkg::REL_FLAGS)
          && ((descriptor_hold[0] != 8'd0) || (descriptor_hold[1] != 8'd0))) begin
        emit                       = 1'b1;
        out_rec_next               = '0;
        out_rec_next.record_kind   = edid_pkg::KIND_TIMING;
        out_rec_next.pixel_clock   = {descriptor_hold[1], descriptor_hold[0]};
        out_rec_next.h_pixels      = {1'b0, ha};
        out_rec_next.h_sync_start  = h_ss;
        out_rec_next.h_sync_end    = h_ss + {3'd0, hsw};
        out_rec_next.h_total       = {1'b0, ha} + {1'b0, hb};
        out_rec_next.v_lines       = {1'b0, va};
        out_rec_next.v_sync_start  = v_ss;
        out_rec_next.v_sync_end    = v_ss + {7'd0, vsw};
        out_rec_next.v_total       = {1'b0, va} + {1'b0, vb};
        out_rec_next.sync_polarity = {b[2], b[1]};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= '0;
      name_active   <= 1'b0;
      name_finished <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (byte_fire) begin
        // advance; the 7-bit count wraps from 127 to 0 by itself
        byte_index    <= idx + 7'd1;
        name_active   <= name_active_next;
        name_finished <= name_finished_next;
      end
      if (bytes.ready) begin
        // register is empty or drained this cycle: load or drop valid
        out_valid <= byte_fire && emit;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers (no reset)
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (byte_fire) begin
      if (idx == edid_pkg::IDX_VERSION) begin
        header_hold[0] <= b;
      end
      if (idx == edid_pkg::IDX_REVISION) begin
        header_hold[1] <= b;
      end
      if (idx == edid_pkg::IDX_WIDTH_CM) begin
        header_hold[2] <= b;
      end
      if (in_mode && !idx[0]) begin
        mode_first_byte <= b;
      end
      if (in_desc && (rel < edid_pkg::REL_FLAGS)) begin
        descriptor_hold[rel] <= b;
      end
      if (emit) begin
        out_rec <= out_rec_next;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output drive
  // --------------------------------------------------------------------------
  assign records.valid         = out_valid;
  assign records.record_kind   = out_rec.record_kind;
  assign records.pixel_clock   = out_rec.pixel_clock;
  assign records.h_pixels      = out_rec.h_pixels;
  assign records.h_sync_start  = out_rec.h_sync_start;
  assign records.h_sync_end    = out_rec.h_sync_end;
  assign records.h_total       = out_rec.h_total;
  assign records.v_lines       = out_rec.v_lines;
  assign records.v_sync_start  = out_rec.v_sync_start;
  assign records.v_sync_end    = out_rec.v_sync_end;
  assign records.v_total       = out_rec.v_total;
  assign records.sync_polarity = out_rec.sync_polarity;
  assign records.name_char     = out_rec.name_char;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_info_follows: assert property (@(posedge clk) disable iff (rst)
    byte_fire && (idx == edid_pkg::IDX_HEIGHT_CM)
      |=> out_valid && (out_rec.record_kind == edid_pkg::KIND_INFO))
    else $error("info record missing after byte 22");

  a_index_advance: assert property (@(posedge clk) disable iff (rst)
    byte_fire |=> byte_index == $past(idx) + 7'd1)
    else $error("byte index did not advance");

  a_name_flags: assert property (@(posedge clk) disable iff (rst)
    name_finished |-> name_active)
    else $error("name finished without an active name descriptor");

  a_stall_only_on_full: assert property (@(posedge clk) disable iff (rst)
    !bytes.ready |-> out_valid && !records.ready)
    else $error("input stalled with output free");

endmodule

// ===== tb/sv/edid_record_compare.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// EDID record comparison
// Watches the byte and record channels of the base block decoder, decodes
// every accepted byte on its own and compares each accepted record field by
// field with the oldest record still owed.
// ----------------------------------------------------------------------------
module edid_record_compare (
  input  logic clk,
  input  logic rst,
  edid_byte_if bytes,
  edid_rec_if  records,
  output int   mismatches,
  output int   pending,
  output int   info_seen,
  output int   mode_seen,
  output int   name_seen,
  output int   timing_seen
);

  typedef logic [edid_pkg::DimW-1:0] dim_t;

  // Own copy of the decoder state
  logic [edid_pkg::IdxW-1:0] next_pos;
  logic [7:0]                desc_bytes [edid_pkg::DescHoldDepth];
  logic [7:0]                version_byte;
  logic [7:0]                revision_byte;
  logic [7:0]                width_cm;
  logic [7:0]                mode_lead;
  logic                      name_on;
  logic                      name_done;

  edid_pkg::rec_t owed_records [$];

  // Decode one byte; give back the record it completes, if any
  task automatic decode_edid_byte(input logic [7:0] b, input logic first,
                                  output logic emits, output edid_pkg::rec_t rec);
    logic [edid_pkg::IdxW-1:0] pos;
    logic [edid_pkg::RelW-1:0] rel;
    int offset;
    int x;
    int y;
    int ha, hb, hfp, hsw, va, vb, vfp, vsw;
    pos      = first ? '0 : next_pos;
    next_pos = pos + 1'b1;
    emits    = 1'b0;
    rec      = '0;
    if (pos == edid_pkg::IDX_VERSION) begin
      version_byte = b;
    end else if (pos == edid_pkg::IDX_REVISION) begin
      revision_byte = b;
    end else if (pos == edid_pkg::IDX_WIDTH_CM) begin
      width_cm = b;
    end else if (pos == edid_pkg::IDX_HEIGHT_CM) begin
      emits             = 1'b1;
      rec.record_kind   = edid_pkg::KIND_INFO;
      rec.h_pixels      = dim_t'(version_byte);
      rec.v_lines       = dim_t'(revision_byte);
      rec.h_total       = dim_t'(width_cm);
      rec.v_total       = dim_t'(b);
    end else if (pos >= edid_pkg::IDX_MODE_FIRST && pos < edid_pkg::IDX_DESC_FIRST) begin
      if (!pos[0]) begin
        mode_lead = b;
      end else begin
        x = (int'(mode_lead) + int'(edid_pkg::MODE_BIAS)) * 8;
        case (edid_pkg::aspect_t'(b[7:6]))
          edid_pkg::ASPECT_16_10: y = x * 10 / 16;
          edid_pkg::ASPECT_4_3:   y = x * 3 / 4;
          edid_pkg::ASPECT_5_4:   y = x * 4 / 5;
          default:                y = x * 9 / 16;
        endcase
        emits           = 1'b1;
        rec.record_kind = edid_pkg::KIND_MODE;
        rec.pixel_clock = 16'(int'(b[5:0]) + int'(edid_pkg::REFRESH_BIAS));
        rec.h_pixels    = dim_t'(x);
        rec.v_lines     = dim_t'(y);
      end
    end else if (pos >= edid_pkg::IDX_DESC_FIRST && pos < edid_pkg::IDX_DESC_END) begin
      offset = (int'(pos) - int'(edid_pkg::IDX_DESC_FIRST)) % int'(edid_pkg::DESC_LEN);
      rel    = offset[edid_pkg::RelW-1:0];
      if (rel == 0) begin
        name_on   = 1'b0;
        name_done = 1'b0;
      end
      if (rel == edid_pkg::REL_TAG && desc_bytes[0] == 8'h00 && desc_bytes[1] == 8'h00 &&
          desc_bytes[2] == 8'h00 && b == edid_pkg::TAG_NAME) begin
        name_on   = 1'b1;
        name_done = 1'b0;
      end
      if (rel >= edid_pkg::REL_TEXT && name_on && !name_done) begin
        if (b == edid_pkg::CHAR_LF) begin
          name_done = 1'b1;
        end else begin
          emits           = 1'b1;
          rec.record_kind = edid_pkg::KIND_NAME;
          rec.name_char   = b;
        end
      end
      if (rel < edid_pkg::REL_FLAGS) begin
        desc_bytes[rel] = b;
      end else if (desc_bytes[0] != 8'h00 || desc_bytes[1] != 8'h00) begin
        ha  = int'({desc_bytes[4][7:4], desc_bytes[2]});
        hb  = int'({desc_bytes[4][3:0], desc_bytes[3]});
        hfp = int'({desc_bytes[11][7:6], desc_bytes[8]});
        hsw = int'({desc_bytes[11][5:4], desc_bytes[9]});
        va  = int'({desc_bytes[7][7:4], desc_bytes[5]});
        vb  = int'({desc_bytes[7][3:0], desc_bytes[6]});
        vfp = int'({desc_bytes[11][3:2], desc_bytes[10][7:4]});
        vsw = int'({desc_bytes[11][1:0], desc_bytes[10][3:0]});
        emits             = 1'b1;
        rec.record_kind   = edid_pkg::KIND_TIMING;
        rec.pixel_clock   = {desc_bytes[1], desc_bytes[0]};
        rec.h_pixels      = dim_t'(ha);
        rec.h_sync_start  = dim_t'(ha + hfp);
        rec.h_sync_end    = dim_t'(ha + hfp + hsw);
        rec.h_total       = dim_t'(ha + hb);
        rec.v_lines       = dim_t'(va);
        rec.v_sync_start  = dim_t'(va + vfp);
        rec.v_sync_end    = dim_t'(va + vfp + vsw);
        rec.v_total       = dim_t'(va + vb);
        rec.sync_polarity = {b[2], b[1]};
      end
    end
  endtask

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    edid_pkg::rec_t got;
    edid_pkg::rec_t want;
    edid_pkg::rec_t fresh;
    logic emits;
    if (rst) begin
      next_pos  = '0;
      name_on   = 1'b0;
      name_done = 1'b0;
      owed_records.delete();
      mismatches  = 0;
      info_seen   = 0;
      mode_seen   = 0;
      name_seen   = 0;
      timing_seen = 0;
    end else begin
      // Check the record beat first: it always belongs to an earlier byte
      if (records.valid && records.ready) begin
        got.record_kind   = records.record_kind;
        got.pixel_clock   = records.pixel_clock;
        got.h_pixels      = records.h_pixels;
        got.h_sync_start  = records.h_sync_start;
        got.h_sync_end    = records.h_sync_end;
        got.h_total       = records.h_total;
        got.v_lines       = records.v_lines;
        got.v_sync_start  = records.v_sync_start;
        got.v_sync_end    = records.v_sync_end;
        got.v_total       = records.v_total;
        got.sync_polarity = records.sync_polarity;
        got.name_char     = records.name_char;
        if (owed_records.size() == 0) begin
          mismatches++;
          $display("%0t: record mismatch, expected none, got kind %0d", $time,
                   got.record_kind);
        end else begin
          want = owed_records.pop_front();
          check_field("record_kind", int'(want.record_kind), int'(got.record_kind));
          check_field("pixel_clock", int'(want.pixel_clock), int'(got.pixel_clock));
          check_field("h_pixels", int'(want.h_pixels), int'(got.h_pixels));
          check_field("h_sync_start", int'(want.h_sync_start), int'(got.h_sync_start));
          check_field("h_sync_end", int'(want.h_sync_end), int'(got.h_sync_end));
          check_field("h_total", int'(want.h_total), int'(got.h_total));
          check_field("v_lines", int'(want.v_lines), int'(got.v_lines));
          check_field("v_sync_start", int'(want.v_sync_start), int'(got.v_sync_start));
          check_field("v_sync_end", int'(want.v_sync_end), int'(got.v_sync_end));
          check_field("v_total", int'(want.v_total), int'(got.v_total));
          check_field("sync_polarity", int'(want.sync_polarity),
                      int'(got.sync_polarity));
          check_field("name_char", int'(want.name_char), int'(got.name_char));
          case (want.record_kind)
            edid_pkg::KIND_INFO: info_seen++;
            edid_pkg::KIND_MODE: mode_seen++;
            edid_pkg::KIND_NAME: name_seen++;
            default:             timing_seen++;
          endcase
        end
      end
      if (bytes.valid && bytes.ready) begin
        decode_edid_byte(bytes.edid_byte, bytes.block_start, emits, fresh);
        if (emits) begin
          owed_records.push_back(fresh);
        end
      end
      pending = owed_records.size();
    end
  end

endmodule

// ===== tb/sv/edid_block_decoder_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// EDID base block decoder test
// Streams a hand-built base block and then many random, cut-short and noisy
// blocks into the decoder under random gaps and output stalls; a comparison
// module beside the decoder checks every record it emits.
// ----------------------------------------------------------------------------
module edid_block_decoder_test;

  // Random part length in bytes, record count at the output hold-off, its length and final idle
  localparam int RandomBytes   = 650;
  localparam int HoldAtRecord  = 60;
  localparam int HoldCycles    = 400;
  localparam int DrainCycles   = 8;

  // Mode byte pairs of the hand-built block: all aspect codes, refresh
  // extremes, the unused 0x01 0x01 pattern and the widest mode
  localparam logic [7:0] MODE_PAIRS [16] = '{
    8'h00, 8'h00,  8'hFF, 8'hFF,  8'h01, 8'h01,  8'h81, 8'h40,
    8'hD1, 8'h80,  8'hA9, 8'hC0,  8'h45, 8'h7F,  8'hB3, 8'h3F
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  edid_byte_if bytes_ch ();
  edid_rec_if  records_ch ();

  int mismatches;
  int pending;
  int info_seen;
  int mode_seen;
  int name_seen;
  int timing_seen;

  logic [7:0] block_bytes [128];
  int         bytes_sent;
  int         starts_sent;
  bit         src_steady;
  bit         snk_steady;

  edid_block_decoder dut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (bytes_ch),
    .records (records_ch)
  );

  edid_record_compare record_compare (
    .clk         (clk),
    .rst         (rst),
    .bytes       (bytes_ch),
    .records     (records_ch),
    .mismatches  (mismatches),
    .pending     (pending),
    .info_seen   (info_seen),
    .mode_seen   (mode_seen),
    .name_seen   (name_seen),
    .timing_seen (timing_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the decoder wedges
  initial begin
    #2_000_000;
    $display("%0t: timed out with %0d records still owed", $time, pending);
    $display("edid_block_decoder_test: FAIL");
    $finish;
  end

  // Offer one byte, called at a falling edge. Hold valid high straight into
  // the next beat when no gap is drawn, so valid gets one update per step.
  task automatic send_byte(input logic [7:0] b, input logic first);
    int gap;
    if ($urandom_range(0, 31) == 0) begin
      src_steady = !src_steady;
    end
    gap = src_steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      bytes_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    bytes_ch.valid       <= 1'b1;
    bytes_ch.edid_byte   <= b;
    bytes_ch.block_start <= first;
    do @(posedge clk); while (!bytes_ch.ready);
    @(negedge clk);
    bytes_sent++;
    if (first) begin
      starts_sent++;
    end
  endtask

  // Send the first count bytes of the block buffer
  task automatic send_block(input int count, input logic lead_start);
    for (int i = 0; i < count; i++) begin
      send_byte(block_bytes[i], (i == 0) && lead_start);
    end
  endtask

  // Drop valid and idle until every owed record has been taken
  task automatic drain_records;
    bytes_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Hand-built block: one descriptor of each flavor and extreme fields
  task automatic fill_directed_block;
    string panel;
    int    base;
    panel = "SAMPLE DISP";
    for (int i = 0; i < 128; i++) begin
      block_bytes[i] = 8'h00;
    end
    for (int i = 1; i < 7; i++) begin
      block_bytes[i] = 8'hFF;
    end
    block_bytes[edid_pkg::IDX_VERSION]   = 8'h01;
    block_bytes[edid_pkg::IDX_REVISION]  = 8'h03;
    block_bytes[edid_pkg::IDX_WIDTH_CM]  = 8'hFF;
    block_bytes[edid_pkg::IDX_HEIGHT_CM] = 8'h00;
    for (int i = 0; i < 16; i++) begin
      block_bytes[edid_pkg::IDX_MODE_FIRST + i] = MODE_PAIRS[i];
    end
    // First descriptor: timing with every bit set, sums near the top
    base = edid_pkg::IDX_DESC_FIRST;
    for (int r = 0; r < edid_pkg::DESC_LEN; r++) begin
      block_bytes[base + r] = 8'hFF;
    end
    // Second: monitor name, ended by a line feed before the last byte
    base = edid_pkg::IDX_DESC_FIRST + edid_pkg::DESC_LEN;
    block_bytes[base + edid_pkg::REL_TAG] = edid_pkg::TAG_NAME;
    for (int r = edid_pkg::REL_TEXT; r < edid_pkg::DESC_LEN; r++) begin
      if (r - edid_pkg::REL_TEXT < panel.len()) begin
        block_bytes[base + r] = panel[r - edid_pkg::REL_TEXT];
      end else if (r - edid_pkg::REL_TEXT == panel.len()) begin
        block_bytes[base + r] = edid_pkg::CHAR_LF;
      end else begin
        block_bytes[base + r] = 8'h41;
      end
    end
    // Third: zero-led descriptor with another tag, must stay silent
    base = edid_pkg::IDX_DESC_FIRST + 2 * edid_pkg::DESC_LEN;
    block_bytes[base + edid_pkg::REL_TAG] = 8'hFF;
    for (int r = edid_pkg::REL_TEXT; r < edid_pkg::DESC_LEN; r++) begin
      block_bytes[base + r] = 8'(8'h30 + r);
    end
    // Fourth: zero clock with nonzero third byte, also silent
    base = edid_pkg::IDX_DESC_FIRST + 3 * edid_pkg::DESC_LEN;
    block_bytes[base + 2] = 8'h12;
    for (int r = 3; r < edid_pkg::DESC_LEN; r++) begin
      block_bytes[base + r] = 8'hFF;
    end
    block_bytes[126] = 8'hFF;
    block_bytes[127] = 8'hA5;
  endtask

  // Random block shaped so each descriptor is usually one real flavor
  task automatic fill_random_block;
    int base;
    int flavor;
    int stop;
    for (int i = 0; i < 128; i++) begin
      block_bytes[i] = 8'($urandom_range(0, 255));
    end
    for (int k = 0; k < 4; k++) begin
      base   = edid_pkg::IDX_DESC_FIRST + k * edid_pkg::DESC_LEN;
      flavor = $urandom_range(0, 9);
      if (flavor < 4) begin
        // timing: force a nonzero clock
        if (block_bytes[base] == 8'h00 && block_bytes[base + 1] == 8'h00) begin
          block_bytes[base + $urandom_range(0, 1)] = 8'($urandom_range(1, 255));
        end
      end else if (flavor < 7) begin
        // monitor name; a stop at the descriptor length means no line feed
        block_bytes[base]     = 8'h00;
        block_bytes[base + 1] = 8'h00;
        block_bytes[base + 2] = 8'h00;
        block_bytes[base + edid_pkg::REL_TAG] = edid_pkg::TAG_NAME;
        stop = $urandom_range(edid_pkg::REL_TEXT, edid_pkg::DESC_LEN);
        for (int r = edid_pkg::REL_TEXT; r < edid_pkg::DESC_LEN; r++) begin
          if (r == stop) begin
            block_bytes[base + r] = edid_pkg::CHAR_LF;
          end else if (r < stop && block_bytes[base + r] == edid_pkg::CHAR_LF) begin
            block_bytes[base + r] = 8'h20;
          end
        end
      end else if (flavor == 7) begin
        // zero-led with some other tag
        block_bytes[base]     = 8'h00;
        block_bytes[base + 1] = 8'h00;
        block_bytes[base + 2] = 8'h00;
        if (block_bytes[base + edid_pkg::REL_TAG] == edid_pkg::TAG_NAME) begin
          block_bytes[base + edid_pkg::REL_TAG] = 8'hFD;
        end
      end else if (flavor == 8) begin
        // zero clock but nonzero third byte
        block_bytes[base]     = 8'h00;
        block_bytes[base + 1] = 8'h00;
        if (block_bytes[base + 2] == 8'h00) begin
          block_bytes[base + 2] = 8'($urandom_range(1, 255));
        end
      end
      // otherwise keep the raw random bytes
    end
  endtask

  // Stimulus: reset, loose bytes, directed block, random blocks, drain, verdict
  initial begin
    int random_from;
    int choice;
    bytes_ch.valid       = 1'b0;
    bytes_ch.edid_byte   = 8'h00;
    bytes_ch.block_start = 1'b0;
    src_steady  = 1'b0;
    bytes_sent  = 0;
    starts_sent = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // A few loose bytes with both flag values and byte extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'hAA, 1'b0);

    // The hand-built block, then wrap past byte 127 without a start flag
    fill_directed_block();
    send_block(128, 1'b1);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hC3, 1'b0);

    // Pause until every record of the directed part is out
    drain_records();

    // Random part: mostly whole blocks, some cut short, some plain noise
    random_from = bytes_sent;
    while (bytes_sent - random_from < RandomBytes) begin
      choice = $urandom_range(0, 9);
      if (choice < 7) begin
        fill_random_block();
        // now and then lean on the index wrap instead of the start flag
        send_block(128, $urandom_range(0, 3) != 0);
      end else if (choice < 9) begin
        fill_random_block();
        send_block($urandom_range(1, 127), 1'b1);
      end else begin
        repeat ($urandom_range(16, 64)) begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
      end
    end

    drain_records();
    repeat (DrainCycles) @(negedge clk);

    $display("Sent %0d bytes with %0d block starts under random gaps and stalls.",
             bytes_sent, starts_sent);
    $display("Checked %0d info, %0d mode, %0d name and %0d timing records.",
             info_seen, mode_seen, name_seen, timing_seen);
    if (mismatches == 0) begin
      $display("edid_block_decoder_test: PASS");
    end else begin
      $display("edid_block_decoder_test: FAIL");
    end
    $finish;
  end

  // Record sink: random stalls before each record, steady stretches, and
  // one long hold-off that lets the output register back up into the input
  initial begin
    int taken;
    int gap;
    records_ch.ready = 1'b0;
    snk_steady = 1'b0;
    taken = 0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) begin
        snk_steady = !snk_steady;
      end
      if (taken == HoldAtRecord) begin
        gap = HoldCycles;
      end else begin
        gap = snk_steady ? 0 : $urandom_range(0, 7);
      end
      if (gap > 0) begin
        records_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      records_ch.ready <= 1'b1;
      do @(posedge clk); while (!records_ch.valid);
      taken++;
      @(negedge clk);
    end
  end

endmodule

// ===== sim.f =====
hdl/edid_pkg.sv
hdl/edid_byte_if.sv
hdl/edid_rec_if.sv
hdl/edid_block_decoder.sv
tb/sv/edid_record_compare.sv
tb/sv/edid_block_decoder_test.sv
